>>> sv/assert_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define JSUD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define JSUD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/jsud_pkg.sv
// Types, constants and helper functions of the JSON string unescape decoder.
package jsud_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_BYTES   = 6;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [2:0]                 count;
        logic [MAX_BYTES-1:0][7:0]  bytes;
        logic                       last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

>>> sv/jsud_front.sv
// Front end: accepts raw bytes, tracks escape state and builds output commands.
module jsud_front
    import jsud_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_mode       r_mode, n_mode;
    logic [1:0]  r_digits, n_digits;
    logic [11:0] r_accum, n_accum;
    logic [7:0]  r_held [3];

    logic        accept;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] cp;
    logic        is_bslash;
    t_cmd        cmd;

    assign {hex_ok, hex_val} = hex_decode(i_byte);
    assign cp        = {r_accum, hex_val};
    assign is_bslash = (i_byte == CH_BSLASH);
    assign accept    = i_valid && !i_full;

    always_comb begin
        n_mode   = r_mode;
        n_digits = r_digits;
        n_accum  = r_accum;
        case (r_mode)
            MODE_ESC: begin
                n_mode = MODE_TEXT;
                if (i_byte == CH_LOW_U && !i_last) begin
                    n_mode   = MODE_HEX;
                    n_digits = 2'd0;
                    n_accum  = '0;
                end
            end
            MODE_HEX: begin
                if (hex_ok && r_digits == 2'd3) begin
                    n_mode   = MODE_TEXT;
                    n_digits = 2'd0;
                    n_accum  = '0;
                end else if (hex_ok && !i_last) begin
                    n_accum  = {r_accum[7:0], hex_val};
                    n_digits = r_digits + 2'd1;
                end else begin
                    n_digits = 2'd0;
                    n_accum  = '0;
                    n_mode   = (is_bslash && !i_last) ? MODE_ESC : MODE_TEXT;
                end
            end
            default: begin
                n_mode = (is_bslash && !i_last) ? MODE_ESC : MODE_TEXT;
            end
        endcase
        if (i_last) begin
            n_mode   = MODE_TEXT;
            n_digits = 2'd0;
            n_accum  = '0;
        end
    end

    always_comb begin
        logic [2:0] cnt;
        cnt       = 3'd0;
        cmd       = '0;
        cmd.last  = i_last;
        case (r_mode)
            MODE_ESC: begin
                if (i_byte == CH_LOW_U) begin
                    if (i_last) begin
                        cmd.bytes[cnt] = CH_BSLASH; cnt = cnt + 3'd1;
                        cmd.bytes[cnt] = CH_LOW_U;  cnt = cnt + 3'd1;
                    end
                end else if (i_byte == CH_LOW_N) begin
                    cmd.bytes[cnt] = CH_LF; cnt = cnt + 3'd1;
                end else if (i_byte == CH_LOW_R) begin
                    cmd.bytes[cnt] = CH_CR; cnt = cnt + 3'd1;
                end else if (i_byte == CH_LOW_T) begin
                    cmd.bytes[cnt] = CH_TAB; cnt = cnt + 3'd1;
                end else begin
                    cmd.bytes[cnt] = i_byte; cnt = cnt + 3'd1;
                end
            end
            MODE_HEX: begin
                if (hex_ok && r_digits == 2'd3) begin
                    if (cp[15:7] == '0) begin
                        cmd.bytes[cnt] = cp[7:0]; cnt = cnt + 3'd1;
                    end else if (cp[15:11] == '0) begin
                        cmd.bytes[cnt] = {3'b110, cp[10:6]}; cnt = cnt + 3'd1;
                        cmd.bytes[cnt] = {2'b10, cp[5:0]};   cnt = cnt + 3'd1;
                    end else begin
                        cmd.bytes[cnt] = {4'b1110, cp[15:12]}; cnt = cnt + 3'd1;
                        cmd.bytes[cnt] = {2'b10, cp[11:6]};    cnt = cnt + 3'd1;
                        cmd.bytes[cnt] = {2'b10, cp[5:0]};     cnt = cnt + 3'd1;
                    end
                end else if (!(hex_ok && !i_last)) begin
                    cmd.bytes[cnt] = CH_BSLASH; cnt = cnt + 3'd1;
                    cmd.bytes[cnt] = CH_LOW_U;  cnt = cnt + 3'd1;
                    for (int k = 0; k < 3; k++) begin
                        if (2'(k) < r_digits) begin
                            cmd.bytes[cnt] = r_held[k]; cnt = cnt + 3'd1;
                        end
                    end
                    if (!(is_bslash && !i_last)) begin
                        cmd.bytes[cnt] = i_byte; cnt = cnt + 3'd1;
                    end
                end
            end
            default: begin
                if (!(is_bslash && !i_last)) begin
                    cmd.bytes[cnt] = i_byte; cnt = cnt + 3'd1;
                end
            end
        endcase
        cmd.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_TEXT;
            r_digits <= 2'd0;
            r_accum  <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_digits <= n_digits;
            r_accum  <= n_accum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_mode == MODE_HEX && hex_ok && !i_last && r_digits != 2'd3) begin
            r_held[r_digits] <= i_byte;
        end
    end

    assign o_stall = i_full;
    assign o_push  = accept && (cmd.count != 3'd0);
    assign o_cmd   = cmd;

endmodule

>>> sv/jsud_fifo.sv
// Command queue between the front end and the byte serializer.
module jsud_fifo
    import jsud_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

`include "assert_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;

    logic do_push, do_pop;

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) r_wptr <= ptr_inc(r_wptr);
            if (do_pop)  r_rptr <= ptr_inc(r_rptr);
            if (do_push && !do_pop)      r_cnt <= r_cnt + CNT_W'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_cmd;
    end

    `JSUD_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_stat.full), "push into full queue")
    `JSUD_ASSERT(a_count_range, i_clk, i_rst_n, r_cnt <= CNT_W'(DEPTH), "queue count out of range")
    `JSUD_ASSERT(a_push_fills, i_clk, i_rst_n, (do_push && !do_pop) |=> !o_stat.empty, "push lost")

endmodule

>>> sv/jsud_back.sv
// Back end: walks the head command and hands out one decoded byte per beat.
module jsud_back
    import jsud_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_q_stat    i_stat,
    input  logic       i_stall,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_run_last,
    output logic       o_string_done
);

`include "assert_macros.svh"

    logic [2:0] r_idx;
    logic       beat;
    logic       at_end;

    assign at_end        = ((r_idx + 3'd1) == i_head.count);
    assign beat          = o_valid && !i_stall;
    assign o_valid       = !i_stat.empty;
    assign o_byte        = i_head.bytes[r_idx];
    assign o_run_last    = at_end;
    assign o_string_done = at_end && i_head.last;
    assign o_pop         = beat && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (beat) begin
            r_idx <= at_end ? 3'd0 : r_idx + 3'd1;
        end
    end

    `JSUD_ASSERT(a_idx_in_cmd, i_clk, i_rst_n, o_valid |-> (r_idx < i_head.count), "index past command")
    `JSUD_ASSERT(a_no_empty_cmd, i_clk, i_rst_n, o_valid |-> (i_head.count != 3'd0), "empty command queued")
    `JSUD_ASSERT(a_head_holds, i_clk, i_rst_n, (beat && !at_end) |=> $stable(i_head), "head changed mid-command")

endmodule

>>> sv/json_string_unescape_decoder.sv
// Top level of the JSON string unescape decoder (raw string body to UTF-8 bytes).
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+--------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_in_byte, i_in_last
//  out     | o_out_valid | i_out_stall | o_out_byte, o_out_run_last, o_out_string_done
//
// One raw byte is taken per cycle while the command queue has room.
// A byte that yields k decoded bytes (0 to 6) holds the output port for k beats;
// the single output port draining the queue sets the sustained rate.
// An input byte's decoded bytes reach the output through the registered command queue.
// Reset is synchronous, with no clearing pass.
// Output stall backs up the queue, and o_in_stall rises once the queue is full.
module json_string_unescape_decoder
    import jsud_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_run_last,
    output logic       o_out_string_done
);

    logic    push, pop;
    t_cmd    cmd, head;
    t_q_stat stat;

    jsud_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .i_full  (stat.full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    jsud_fifo #(.DEPTH(DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    jsud_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_stat        (stat),
        .i_stall       (i_out_stall),
        .o_pop         (pop),
        .o_valid       (o_out_valid),
        .o_byte        (o_out_byte),
        .o_run_last    (o_out_run_last),
        .o_string_done (o_out_string_done)
    );

endmodule
